[sv/srwc_pkg.sv]
// ----------------------------------------------------------------------------
// srwc_pkg
// shared types and constants of the superpixel row weight classifier
// ----------------------------------------------------------------------------
package srwc_pkg;

	localparam int LABELS_DEF      = 1024;
	localparam int ROWS_DEF        = 1024;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 20;

	localparam int OP_BITS  = 2;
	localparam int LBL_BITS = 10;
	localparam int ROW_BITS = 10;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_ACC   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_SKY      = 2'd0,
		CLS_VERTICAL = 2'd1,
		CLS_GROUND   = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_READ,
		BK_ACC,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

[sv/superpixel_row_weight_classifier.sv]
// ----------------------------------------------------------------------------
// superpixel_row_weight_classifier
// per-superpixel weight accumulation, averaging and sky/vertical/ground class
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: op, label, row, weight_sky, weight_vertical, weight_ground
// m_axis   out  tdata: avg_sky, avg_vertical, avg_ground, pixel_count, class_code
// cfg      in   class_mode, written when cfg_we is high
//
// load writes the weight table; accumulate reads memory, then does a read-modify-write
// query runs the three averages through the shared divider, which is skipped if empty
// clear sweeps the accumulator memory; reset runs the same sweep
// a 4-word queue lets the input run ahead while the back end stalls on output
// ----------------------------------------------------------------------------
module superpixel_row_weight_classifier #(
	parameter int LABELS      = srwc_pkg::LABELS_DEF,
	parameter int ROWS        = srwc_pkg::ROWS_DEF,
	parameter int WEIGHT_BITS = srwc_pkg::WEIGHT_BITS_DEF,
	parameter int COUNT_BITS  = srwc_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// op, label, row, weight_sky, weight_vertical, weight_ground, zero pad
	input  logic [((22+3*WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// avg_sky, avg_vertical, avg_ground, pixel_count, class_code, zero pad
	output logic [((3*WEIGHT_BITS+COUNT_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
	import srwc_pkg::*;

	localparam int CW = 23 + 3 * WEIGHT_BITS;
	localparam int RW = 3 * WEIGHT_BITS + COUNT_BITS + 2;
	localparam int OW = ((RW + 7) / 8) * 8;

	logic            mode_q;
	logic            cmd_valid, cmd_ready;
	logic [CW-1:0]   cmd_data;
	logic [RW-1:0]   res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	srwc_front #(.LABELS(LABELS), .ROWS(ROWS), .WEIGHT_BITS(WEIGHT_BITS),
		.CW(CW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tdata[1:0]), .in_label(s_axis_tdata[11:2]),
		.in_row(s_axis_tdata[21:12]),
		.in_w(s_axis_tdata[22+3*WEIGHT_BITS-1:22]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
	);

	srwc_back #(.LABELS(LABELS), .ROWS(ROWS), .WEIGHT_BITS(WEIGHT_BITS),
		.COUNT_BITS(COUNT_BITS), .CW(CW)) u_back (
		.clk(clk), .arst_n(arst_n), .class_mode(mode_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res_data)
	);

	assign m_axis_tdata = OW'(res_data);
endmodule

[sv/srwc_front.sv]
// ----------------------------------------------------------------------------
// srwc_front
// accepts words, range-checks them and queues commands for the back part
// ----------------------------------------------------------------------------
module srwc_front #(
	parameter int LABELS      = srwc_pkg::LABELS_DEF,
	parameter int ROWS        = srwc_pkg::ROWS_DEF,
	parameter int WEIGHT_BITS = srwc_pkg::WEIGHT_BITS_DEF,
	parameter int CW          = 23 + 3 * srwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_op,
	input  logic [9:0]               in_label,
	input  logic [9:0]               in_row,
	input  logic [3*WEIGHT_BITS-1:0] in_w,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output logic [CW-1:0]            cmd_data
);
	import srwc_pkg::*;

	localparam int DEPTH = 4;

	logic [CW-1:0] fifo_q [DEPTH];
	logic [1:0]    wp_q, rp_q;
	logic [2:0]    cnt_q;
	logic          push, pop;
	logic          keep;
	logic          row_ok, lbl_ok;

	// command word: op, label, row, label ok, weights (low bits up)
	assign row_ok = 32'(in_row) < ROWS;
	assign lbl_ok = 32'(in_label) < LABELS;
	always_comb begin
		case (op_t'(in_op))
			OP_LOAD:  keep = row_ok;
			OP_ACC:   keep = row_ok && lbl_ok;
			default:  keep = 1'b1;
		endcase
	end

	assign in_ready  = cnt_q != 3'(DEPTH);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = cnt_q != 3'd0;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd_data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= CW'({in_w, lbl_ok, in_row, in_label, in_op});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(DEPTH))
		else $error("queue overfill");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'(DEPTH)) |-> !push) else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0) |-> !pop) else $error("pop from empty queue");
endmodule

[sv/srwc_div.sv]
// ----------------------------------------------------------------------------
// srwc_div
// signed by unsigned restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module srwc_div #(
	parameter int NB = 36,
	parameter int DB = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          done,
	output logic [NB-1:0] quo
);
	localparam int CB = $clog2(NB + 1);

	logic [NB-1:0] q_q;
	logic [DB:0]   r_q;
	logic [DB-1:0] d_q;
	logic          neg_q;
	logic [CB-1:0] k_q;
	logic          busy_q;
	logic [DB:0]   trial;
	logic [DB:0]   sub;

	assign trial = {r_q[DB-1:0], q_q[NB-1]};
	assign sub   = trial - {1'b0, d_q};
	assign done  = busy_q && k_q == '0;
	assign quo   = neg_q ? -q_q : q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[NB-1] ? -num : num;
			neg_q <= num[NB-1];
			d_q   <= den;
			r_q   <= '0;
		end else if (busy_q && k_q != '0) begin
			if (!sub[DB]) begin
				r_q <= sub;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= CB'(NB);
		end else if (busy_q) begin
			if (k_q == '0) busy_q <= 1'b0;
			else k_q <= k_q - 1'b1;
		end
	end
endmodule

[sv/srwc_back.sv]
// ----------------------------------------------------------------------------
// srwc_back
// weight tables, per-label accumulators, query divide and classification
// ----------------------------------------------------------------------------
module srwc_back #(
	parameter int LABELS      = srwc_pkg::LABELS_DEF,
	parameter int ROWS        = srwc_pkg::ROWS_DEF,
	parameter int WEIGHT_BITS = srwc_pkg::WEIGHT_BITS_DEF,
	parameter int COUNT_BITS  = srwc_pkg::COUNT_BITS_DEF,
	parameter int CW          = 23 + 3 * srwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         class_mode,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [CW-1:0]                cmd_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [3*WEIGHT_BITS+COUNT_BITS+1:0] res_data
);
	import srwc_pkg::*;

	localparam int LB = (LABELS > 1) ? $clog2(LABELS) : 1;
	localparam int RB = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WB = WEIGHT_BITS;
	localparam int SB = WEIGHT_BITS + COUNT_BITS;
	localparam int ENT = 3 * SB + COUNT_BITS;

	// weight memory, written from the queued load command
	logic [3*WB-1:0] wmem [ROWS];
	logic [ENT-1:0]  amem [LABELS];
	logic [3*WB-1:0] wrd_q;
	logic [ENT-1:0]  ard_q;

	bk_state_t st_q, st_d;
	logic [LB:0]     clr_q;
	logic [1:0]      op;
	logic [9:0]      lbl, rw;
	logic            lbl_ok;
	logic [3*WB-1:0] wdata;
	logic            wr_load;
	logic [1:0]      idx_q;
	logic [1:0]      sel_idx;
	logic [WB-1:0]   avg_q [3];
	logic [COUNT_BITS-1:0] n_q;
	logic [SB-1:0]   sum_sel;
	logic            dstart;
	logic            ddone;
	logic [SB-1:0]   dquo;
	logic            awr;
	logic [LB-1:0]   aaddr;
	logic [ENT-1:0]  awdata;
	logic [SB-1:0]   s0, s1, s2;
	logic [COUNT_BITS-1:0] cnt;
	logic signed [WB-1:0] as, av, ag;
	cls_t            cls;

	assign op     = cmd_data[1:0];
	assign lbl    = cmd_data[11:2];
	assign rw     = cmd_data[21:12];
	assign lbl_ok = cmd_data[22];
	assign wdata  = cmd_data[23 +: 3*WB];
	assign {cnt, s2, s1, s0} = ard_q;

	assign wr_load = cmd_valid && (st_q == BK_IDLE) && (op_t'(op) == OP_LOAD);

	always_ff @(posedge clk) begin
		if (wr_load) wmem[RB'(rw)] <= wdata;
		wrd_q <= wmem[RB'(rw)];
	end

	always_ff @(posedge clk) begin
		if (awr) amem[aaddr] <= awdata;
		ard_q <= amem[LB'(lbl)];
	end

	// sum fed to the divider as it starts: sky first, then the next one
	assign sel_idx = (st_q == BK_READ) ? 2'd0 : idx_q + 2'd1;

	always_comb begin
		case (sel_idx)
			2'd0:    sum_sel = s0;
			2'd1:    sum_sel = s1;
			default: sum_sel = s2;
		endcase
	end

	srwc_div #(.NB(SB), .DB(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(sum_sel),
		.den(cnt), .done(ddone), .quo(dquo)
	);

	always_comb begin
		st_d      = st_q;
		cmd_ready = 1'b0;
		awr       = 1'b0;
		aaddr     = LB'(lbl);
		awdata    = ard_q;
		dstart    = 1'b0;
		case (st_q)
			BK_CLEAR: begin
				awr    = 1'b1;
				aaddr  = clr_q[LB-1:0];
				awdata = '0;
				if (32'(clr_q) == LABELS - 1) st_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (cmd_valid) begin
					case (op_t'(op))
						OP_LOAD:  cmd_ready = 1'b1;
						OP_CLEAR: begin
							cmd_ready = 1'b1;
							st_d      = BK_CLEAR;
						end
						default:  st_d = BK_READ;
					endcase
				end
			end
			BK_READ: begin
				if (op_t'(op) == OP_ACC) st_d = BK_ACC;
				else if (!lbl_ok || cnt == '0) st_d = BK_OUT;
				else begin
					dstart = 1'b1;
					st_d   = BK_DIV;
				end
			end
			BK_ACC: begin
				cmd_ready = 1'b1;
				st_d      = BK_IDLE;
				if (cnt != '1) begin
					awr    = 1'b1;
					awdata = {cnt + 1'b1,
						s2 + SB'($signed(wrd_q[3*WB-1:2*WB])),
						s1 + SB'($signed(wrd_q[2*WB-1:WB])),
						s0 + SB'($signed(wrd_q[WB-1:0]))};
				end
			end
			BK_DIV: begin
				if (ddone) begin
					if (idx_q == 2'd2) st_d = BK_OUT;
					else dstart = 1'b1;
				end
			end
			BK_OUT: begin
				if (!res_valid) begin
					cmd_ready = 1'b1;
					st_d      = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_READ) begin
			idx_q <= 2'd0;
			n_q   <= lbl_ok ? cnt : '0;
			for (int i = 0; i < 3; i++) avg_q[i] <= '0;
		end else if (st_q == BK_DIV && ddone) begin
			avg_q[idx_q] <= dquo[WB-1:0];
			idx_q        <= idx_q + 2'd1;
		end
	end

	assign as = avg_q[0];
	assign av = avg_q[1];
	assign ag = avg_q[2];
	always_comb begin
		if (class_mode) cls = (av >= ag) ? CLS_VERTICAL : CLS_GROUND;
		else if (as >= av && as >= ag) cls = CLS_SKY;
		else if (av >= ag) cls = CLS_VERTICAL;
		else cls = CLS_GROUND;
	end

	// result register parts the back end from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BK_CLEAR;
			clr_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (st_q == BK_OUT && !res_valid) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_OUT && !res_valid) begin
			res_data <= {cls, n_q, avg_q[2], avg_q[1], avg_q[0]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_CLEAR) |-> !cmd_ready) else $error("command taken while clearing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable(res_data)) else $error("result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_ACC) |-> cmd_ready) else $error("accumulate not retired");
endmodule

[dv/srwc_checker.sv]
// ----------------------------------------------------------------------------
// srwc_checker
// watches both streams of the classifier, predicts query answers and compares
// ----------------------------------------------------------------------------
module srwc_checker
	import srwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// op, label, row, weight_sky, weight_vertical, weight_ground, zero pad
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// avg_sky, avg_vertical, avg_ground, pixel_count, class_code, zero pad
	input  logic [71:0] m_axis_tdata,
	output int          fail_count,
	output int          pending,
	output int          answers_seen
);

	typedef struct packed {
		logic signed [15:0] sky;
		logic signed [15:0] vert;
		logic signed [15:0] gnd;
		logic [19:0]        cnt;
		cls_t               cls;
	} answer_t;

	localparam logic [19:0] CNT_MAX = 20'hFFFFF;

	logic signed [15:0] tbl_sky  [1024];
	logic signed [15:0] tbl_vert [1024];
	logic signed [15:0] tbl_gnd  [1024];
	longint             sum_sky  [1024];
	longint             sum_vert [1024];
	longint             sum_gnd  [1024];
	logic [19:0]        lbl_cnt  [1024];
	logic               two_class;
	answer_t            answer_q [$];

	function automatic longint mean(longint s, logic [19:0] n);
		if (n == 0) return 0;
		return s / longint'(n);
	endfunction

	function automatic answer_t answer_label(logic [9:0] lbl);
		answer_t a;
		a.cnt  = lbl_cnt[lbl];
		a.sky  = 16'(mean(sum_sky[lbl], a.cnt));
		a.vert = 16'(mean(sum_vert[lbl], a.cnt));
		a.gnd  = 16'(mean(sum_gnd[lbl], a.cnt));
		if (two_class) a.cls = (a.vert >= a.gnd) ? CLS_VERTICAL : CLS_GROUND;
		else if (a.sky >= a.vert && a.sky >= a.gnd) a.cls = CLS_SKY;
		else if (a.vert >= a.gnd) a.cls = CLS_VERTICAL;
		else a.cls = CLS_GROUND;
		return a;
	endfunction

	task automatic clear_sums();
		for (int i = 0; i < 1024; i++) begin
			sum_sky[i] = 0; sum_vert[i] = 0; sum_gnd[i] = 0; lbl_cnt[i] = 0;
		end
	endtask

	assign pending = answer_q.size();

	initial begin
		fail_count = 0;
		answers_seen = 0;
		two_class = 1'b0;
		clear_sums();
	end

	always @(posedge clk) begin
		op_t        op;
		logic [9:0] lbl, rw;
		answer_t    got, want;
		if (arst_n) begin
			if (cfg_we) two_class = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				op  = op_t'(s_axis_tdata[1:0]);
				lbl = s_axis_tdata[11:2];
				rw  = s_axis_tdata[21:12];
				case (op)
					OP_LOAD: begin
						tbl_sky[rw]  = s_axis_tdata[37:22];
						tbl_vert[rw] = s_axis_tdata[53:38];
						tbl_gnd[rw]  = s_axis_tdata[69:54];
					end
					OP_CLEAR: clear_sums();
					OP_ACC: begin
						if (lbl_cnt[lbl] != CNT_MAX) begin
							sum_sky[lbl]  += tbl_sky[rw];
							sum_vert[lbl] += tbl_vert[rw];
							sum_gnd[lbl]  += tbl_gnd[rw];
							lbl_cnt[lbl]++;
						end
					end
					default: answer_q.push_back(answer_label(lbl));
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.sky  = m_axis_tdata[15:0];
				got.vert = m_axis_tdata[31:16];
				got.gnd  = m_axis_tdata[47:32];
				got.cnt  = m_axis_tdata[67:48];
				got.cls  = cls_t'(m_axis_tdata[69:68]);
				answers_seen++;
				if (answer_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected word %h", m_axis_tdata);
				end else begin
					want = answer_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp sky %0d vert %0d gnd %0d cnt %0d cls %0d",
								want.sky, want.vert, want.gnd, want.cnt, want.cls);
							$display("          got sky %0d vert %0d gnd %0d cnt %0d cls %0d",
								got.sky, got.vert, got.gnd, got.cnt, got.cls);
						end
					end
				end
			end
		end
	end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// random and directed stimulus for the superpixel row weight classifier
// ----------------------------------------------------------------------------
// weight rows are loaded before any pixel uses them, pixels are mostly spread
// over a few labels so queries see real averages; the checker predicts answers
// ----------------------------------------------------------------------------
module tb_top;
	import srwc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	int          fail_count, pending, answers_seen;
	int          send_idle, recv_stall;
	int          cycles;
	int          hold_off;
	int          n_items;
	logic        loaded [1024];
	logic [9:0]  loaded_rows [$];

	superpixel_row_weight_classifier u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	srwc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending(pending), .answers_seen(answers_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 900000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// valid stays high into the next word unless the sender idles
	task automatic send(op_t op, logic [9:0] lbl, logic [9:0] rw,
			logic [15:0] ws, logic [15:0] wv, logic [15:0] wg);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {2'b0, wg, wv, ws, rw, lbl, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		if (op == OP_LOAD && !loaded[rw]) begin
			loaded[rw] = 1'b1;
			loaded_rows.push_back(rw);
		end
		n_items++;
	endtask

	// long enough for a full queue of clears to sweep
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (5500) @(negedge clk);
	endtask

	task automatic set_mode(logic m);
		drain();
		cfg_wdata <= m;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [9:0] any_row();
		return loaded_rows[$urandom_range(loaded_rows.size() - 1)];
	endfunction

	task automatic random_item(int nlab);
		int k;
		logic [9:0] lbl;
		k = $urandom_range(99);
		lbl = (nlab > 0) ? 10'($urandom_range(nlab - 1)) : 10'($urandom);
		if ($urandom_range(9) == 0) lbl = 10'($urandom);
		if (k < 10)
			send(OP_LOAD, 10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		else if (k < 12)
			send(OP_CLEAR, 10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		else if (k < 80)
			send(OP_ACC, lbl, any_row(), 16'($urandom), 16'($urandom), 16'($urandom));
		else
			send(OP_QUERY, lbl, 10'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		n_items = 0;
		for (int i = 0; i < 1024; i++) loaded[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme weights, ties, empty and high labels, clear
		send(OP_QUERY, 10'd0, 10'd0, '0, '0, '0);
		send(OP_LOAD, 10'd0, 10'd0, 16'h8000, 16'h8000, 16'h8000);
		send(OP_LOAD, 10'd0, 10'd1023, 16'h7FFF, 16'h7FFF, 16'h8000);
		send(OP_LOAD, 10'd0, 10'd5, 16'h0001, 16'hFFFF, 16'h0100);
		send(OP_LOAD, 10'd0, 10'd6, 16'hFFFD, 16'h0002, 16'h0003);
		send(OP_ACC, 10'd1023, 10'd0, '0, '0, '0);
		send(OP_ACC, 10'd1023, 10'd1023, '0, '0, '0);
		send(OP_ACC, 10'd7, 10'd5, '0, '0, '0);
		send(OP_ACC, 10'd7, 10'd6, '0, '0, '0);
		send(OP_ACC, 10'd7, 10'd6, '0, '0, '0);
		send(OP_ACC, 10'd3, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd1023, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(OP_QUERY, 10'd7, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd3, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd500, 10'd0, '0, '0, '0);
		set_mode(1'b1);
		send(OP_QUERY, 10'd1023, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd7, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd500, 10'd0, '0, '0, '0);
		send(OP_CLEAR, 10'd0, 10'd0, '0, '0, '0);
		send(OP_QUERY, 10'd7, 10'd0, '0, '0, '0);
		set_mode(1'b0);

		// idling phases: none, sender, receiver, both
		for (int ph = 0; ph < 8; ph++) begin
			send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 10 : 52) : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 10 : 52) : 0;
			if (ph == 2) hold_off = 3000;
			for (int i = 0; i < 80; i++) random_item((ph < 4) ? 4 : 24);
			if (ph == 3) set_mode(1'b1);
			if (ph == 6) set_mode(1'b0);
		end
		send_idle = 0;

		drain();
		$display("sent %0d words, checked %0d query answers in both class modes",
			n_items, answers_seen);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

[superpixel_row_weight_classifier.f]
sv/srwc_pkg.sv
sv/srwc_front.sv
sv/srwc_div.sv
sv/srwc_back.sv
sv/superpixel_row_weight_classifier.sv
dv/srwc_checker.sv
dv/tb_top.sv
